/* hdl/swqh_pkg.sv */
// Shared types and constants for the sliding window quantile histogram.
// No dependencies; every other file in hdl uses this package by scoped name.
`default_nettype none
package swqh_pkg;

   localparam int WINDOW_MAX = 1024;
   localparam int NUM_BINS   = 251;
   localparam int WIN_AW     = $clog2(WINDOW_MAX);
   localparam int BIN_AW     = $clog2(NUM_BINS);
   localparam int FILL_W     = WIN_AW + 1;
   localparam int VALUE_W    = 16;
   localparam int COUNT_W    = 20;
   localparam int STEP_W     = 16;
   localparam int PCT_W      = 7;
   localparam int CSR_DW     = 20;
   localparam int CSR_AW     = 2;

   // fixed-point constants: cutoff 5.0 in Q8.8 and bins at 1/50
   localparam logic [VALUE_W-1:0] CUTOFF_Q88 = 16'd1280;
   localparam logic [VALUE_W-1:0] BIN_RES    = 16'd50;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   // divide by 100 as multiply by ceil(2^24 / 100) and shift by 24;
   // exact for every n * percent product below 2^17
   localparam int         PCT_SHIFT = 24;
   localparam int         PCT_RW    = 18;
   localparam logic [17:0] PCT_RECIP = 18'd167773;

   // request op codes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_BREAK  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_WIDTH   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_STEP    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_PERCENT = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_MAXWIN  = 2'd3;

   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [1:0] {
      CMD_SAMPLE,
      CMD_BREAK,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [VALUE_W-1:0]  value;
      logic [7:0]          bin_index;
   } cmd_type;

   typedef struct packed {
      logic                kind;
      logic [7:0]          bin;
      logic [COUNT_W-1:0]  bin_count;
      logic [COUNT_W-1:0]  windows_done;
   } rsp_type;

   typedef struct packed {
      logic [FILL_W-1:0]   window_width;
      logic [STEP_W-1:0]   window_step;
      logic [PCT_W-1:0]    percent_cutoff;
      logic [COUNT_W-1:0]  max_windows;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_KSET,
      ST_SCAN,
      ST_DRAIN,
      ST_BIT,
      ST_BIN,
      ST_HRQ,
      ST_HUPD,
      ST_HRD
   } state_type;

endpackage
`default_nettype wire

/* hdl/swqh_front.sv */
// Front end: takes request beats, classifies the op and queues commands.
// Depends on swqh_pkg.
`default_nettype none
module swqh_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [1:0]         req_op,
   input  wire logic [15:0]        req_error_value,
   input  wire logic [7:0]         req_bin_index,
   output logic                    cmd_valid,
   output swqh_pkg::cmd_type       cmd,
   input  wire logic               cmd_pop
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   swqh_pkg::cmd_type q_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          take;
   logic          keep;
   swqh_pkg::cmd_type new_cmd;

   // classify: unused op codes are taken and dropped here
   always_comb begin
      new_cmd.value     = req_error_value;
      new_cmd.bin_index = req_bin_index;
      keep              = 1'b1;
      unique case (req_op)
         swqh_pkg::OP_SAMPLE: new_cmd.kind = swqh_pkg::CMD_SAMPLE;
         swqh_pkg::OP_BREAK:  new_cmd.kind = swqh_pkg::CMD_BREAK;
         swqh_pkg::OP_READ:   new_cmd.kind = swqh_pkg::CMD_READ;
         default: begin
            new_cmd.kind = swqh_pkg::CMD_SAMPLE;
            keep         = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == (PW+1)'(DEPTH));
   assign take      = req_push && !req_full && keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   // pointer update
   always_comb begin
      wr_ptr_in = take ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(take) - (PW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

/* hdl/swqh_rsp_fifo.sv */
// Two-entry result queue between the back end and the response port.
// Depends on swqh_pkg.
`default_nettype none
module swqh_rsp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire swqh_pkg::rsp_type  push_data,
   output logic                    full,
   output logic                    empty,
   input  wire logic               pop,
   output swqh_pkg::rsp_type       pop_data
);

   swqh_pkg::rsp_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_pop   = pop && !empty;
   assign pop_data = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* hdl/swqh_back.sv */
// Back end: window ring, radix quantile select, binning and histogram.
// Depends on swqh_pkg.
`default_nettype none
module swqh_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire swqh_pkg::cfg_type  cfg,
   input  wire logic               cmd_valid,
   input  wire swqh_pkg::cmd_type  cmd,
   output logic                    cmd_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output swqh_pkg::rsp_type       rsp_data
);

   localparam int FW = swqh_pkg::FILL_W;
   localparam int AW = swqh_pkg::WIN_AW;
   localparam int VW = swqh_pkg::VALUE_W;
   localparam int CW = swqh_pkg::COUNT_W;
   localparam int BW = swqh_pkg::BIN_AW;
   localparam int DW = FW + swqh_pkg::PCT_W - 1;  // n * percent
   localparam int RW = DW + swqh_pkg::PCT_RW;     // reciprocal product

   // memories
   logic [VW-1:0] win_mem  [swqh_pkg::WINDOW_MAX];
   logic [CW-1:0] hist_mem [swqh_pkg::NUM_BINS];

   swqh_pkg::state_type state_ff, state_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [swqh_pkg::STEP_W-1:0] slide_ff, slide_in;
   logic [CW-1:0]     total_ff, total_in;
   logic [DW-1:0]     div_ff, div_in;
   logic [FW-1:0]     n_ff, n_in;
   logic [FW-1:0]     k_ff, k_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [FW-1:0]     cnt_ff, cnt_in;
   logic [3:0]        bit_ff, bit_in;
   logic [VW-1:0]     prefix_ff, prefix_in;
   logic [VW-1:0]     prod_ff, prod_in;
   logic [BW-1:0]     hbin_ff, hbin_in;
   logic              hrange_ff, hrange_in;
   logic              rd_vld_ff;
   logic [VW-1:0]     rd_data_ff;
   logic [CW-1:0]     hist_rd_ff;
   logic [swqh_pkg::NUM_BINS-1:0] hvalid_ff;

   logic              win_we;
   logic [AW-1:0]     win_waddr, win_raddr;
   logic              hist_we;
   logic [CW-1:0]     hist_wdata, hist_cur;
   logic [BW-1:0]     hist_raddr;
   logic              hv;

   logic [FW-1:0]     w_eff;
   logic [swqh_pkg::STEP_W-1:0] step_eff, slide_next;
   logic [VW-1:0]     hi_mask;
   logic              match;
   logic [RW-1:0]     recip_prod;
   logic [VW-1:0]     q_clamp;
   logic [7:0]        b_raw;
   logic [BW-1:0]     b_clamp;

   // effective configuration
   always_comb begin
      if (cfg.window_width == '0) begin
         w_eff = FW'(1);
      end else if (cfg.window_width > FW'(swqh_pkg::WINDOW_MAX)) begin
         w_eff = FW'(swqh_pkg::WINDOW_MAX);
      end else begin
         w_eff = cfg.window_width;
      end
      step_eff   = (cfg.window_step == '0) ? swqh_pkg::STEP_W'(1) : cfg.window_step;
      slide_next = (slide_ff == '1) ? slide_ff : slide_ff + 1'b1;
   end

   // radix select compare: bits above the current bit match the prefix and the current bit is clear
   assign hi_mask = 16'hFFFE << bit_ff;
   assign match   = (((rd_data_ff ^ prefix_ff) & hi_mask) == '0) && !rd_data_ff[bit_ff];

   // n * percent / 100 by reciprocal multiply
   assign recip_prod = RW'(div_ff) * RW'(swqh_pkg::PCT_RECIP);

   assign q_clamp = (prefix_ff > swqh_pkg::CUTOFF_Q88) ? swqh_pkg::CUTOFF_Q88 : prefix_ff;
   assign b_raw   = prod_ff[15:8];
   assign b_clamp = (b_raw > 8'(swqh_pkg::NUM_BINS - 1)) ?
                    BW'(swqh_pkg::NUM_BINS - 1) : BW'(b_raw);

   assign hv       = hrange_ff ? hvalid_ff[hbin_ff] : 1'b0;
   assign hist_cur = hv ? hist_rd_ff : '0;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      oldest_in  = oldest_ff;
      slide_in   = slide_ff;
      total_in   = total_ff;
      div_in     = div_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      bit_in     = bit_ff;
      prefix_in  = prefix_ff;
      prod_in    = prod_ff;
      hbin_in    = hbin_ff;
      hrange_in  = hrange_ff;
      cmd_pop    = 1'b0;
      win_we     = 1'b0;
      win_waddr  = oldest_ff;
      win_raddr  = oldest_ff + idx_ff;
      hist_we    = 1'b0;
      hist_wdata = (hist_cur == swqh_pkg::COUNT_MAX) ? hist_cur : hist_cur + 1'b1;
      hist_raddr = hbin_ff;
      rsp_push   = 1'b0;
      rsp_data   = '0;

      // count matching entries as read data returns
      if (rd_vld_ff && match) begin
         cnt_in = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         swqh_pkg::ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  swqh_pkg::CMD_BREAK: begin
                     fill_in   = '0;
                     oldest_in = '0;
                     slide_in  = '0;
                  end
                  swqh_pkg::CMD_READ: begin
                     hbin_in    = BW'(cmd.bin_index);
                     hist_raddr = BW'(cmd.bin_index);
                     hrange_in  = (cmd.bin_index < 8'(swqh_pkg::NUM_BINS));
                     state_in   = swqh_pkg::ST_HRD;
                  end
                  default: begin
                     if (total_ff < cfg.max_windows) begin
                        win_we = 1'b1;
                        if (fill_ff < w_eff) begin
                           win_waddr = oldest_ff + AW'(fill_ff);
                           fill_in   = fill_ff + 1'b1;
                        end else begin
                           oldest_in = oldest_ff + 1'b1;
                           if (slide_next < step_eff) begin
                              slide_in = slide_next;
                           end else begin
                              slide_in = '0;
                              n_in     = fill_ff;
                              div_in   = DW'(fill_ff) * DW'(cfg.percent_cutoff);
                              state_in = swqh_pkg::ST_DIV;
                           end
                        end
                     end
                  end
               endcase
            end
         end
         swqh_pkg::ST_DIV: begin
            div_in   = DW'(recip_prod >> swqh_pkg::PCT_SHIFT);
            state_in = swqh_pkg::ST_KSET;
         end
         swqh_pkg::ST_KSET: begin
            // quotient limited to n-1
            k_in      = (div_ff > DW'(n_ff - 1'b1)) ? n_ff - 1'b1 : FW'(div_ff);
            idx_in    = '0;
            cnt_in    = '0;
            bit_in    = 4'(VW - 1);
            prefix_in = '0;
            state_in  = swqh_pkg::ST_SCAN;
         end
         swqh_pkg::ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (FW'(idx_ff) == n_ff - 1'b1) begin
               state_in = swqh_pkg::ST_DRAIN;
            end
         end
         swqh_pkg::ST_DRAIN: begin
            state_in = swqh_pkg::ST_BIT;
         end
         swqh_pkg::ST_BIT: begin
            if (k_ff >= cnt_ff) begin
               prefix_in = prefix_ff | (16'd1 << bit_ff);
               k_in      = k_ff - cnt_ff;
            end
            if (bit_ff == '0) begin
               state_in = swqh_pkg::ST_BIN;
            end else begin
               bit_in   = bit_ff - 1'b1;
               idx_in   = '0;
               cnt_in   = '0;
               state_in = swqh_pkg::ST_SCAN;
            end
         end
         swqh_pkg::ST_BIN: begin
            prod_in  = 16'(q_clamp * swqh_pkg::BIN_RES);
            state_in = swqh_pkg::ST_HRQ;
         end
         swqh_pkg::ST_HRQ: begin
            hbin_in    = b_clamp;
            hist_raddr = b_clamp;
            hrange_in  = 1'b1;
            state_in   = swqh_pkg::ST_HUPD;
         end
         swqh_pkg::ST_HUPD: begin
            hist_we                = 1'b1;
            total_in               = total_ff + 1'b1;
            rsp_push               = 1'b1;
            rsp_data.kind          = swqh_pkg::KIND_WINDOW;
            rsp_data.bin           = 8'(hbin_ff);
            rsp_data.bin_count     = hist_wdata;
            rsp_data.windows_done  = total_ff + 1'b1;
            state_in               = swqh_pkg::ST_IDLE;
         end
         swqh_pkg::ST_HRD: begin
            rsp_push              = 1'b1;
            rsp_data.kind         = swqh_pkg::KIND_READ;
            rsp_data.bin          = 8'(hbin_ff);
            rsp_data.bin_count    = hist_cur;
            rsp_data.windows_done = total_ff;
            state_in              = swqh_pkg::ST_IDLE;
         end
         default: begin
            state_in = swqh_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= swqh_pkg::ST_IDLE;
         fill_ff   <= '0;
         oldest_ff <= '0;
         slide_ff  <= '0;
         total_ff  <= '0;
         rd_vld_ff <= 1'b0;
         hvalid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
         slide_ff  <= slide_in;
         total_ff  <= total_in;
         rd_vld_ff <= (state_ff == swqh_pkg::ST_SCAN);
         if (hist_we) begin
            hvalid_ff[hbin_ff] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      bit_ff    <= bit_in;
      prefix_ff <= prefix_in;
      prod_ff   <= prod_in;
      hbin_ff   <= hbin_in;
      hrange_ff <= hrange_in;
   end

   // window ring
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= cmd.value;
      end
      rd_data_ff <= win_mem[win_raddr];
   end

   // histogram
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hbin_ff] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
   end

endmodule
`default_nettype wire

/* hdl/sliding_window_quantile_histogram.sv */
// Top level: registers, front end, back end and result queue.
// Depends on swqh_pkg, swqh_front, swqh_back, swqh_rsp_fifo.
//
//   channel | ports                               | beat
//   req     | req_push/req_full, op, value, bin   | push && !full
//   rsp     | rsp_pop/rsp_empty, kind, bin, counts| pop && !empty
//   csr     | csr_we, csr_index, csr_wdata        | csr_we
//
// A break, or a sample that does not close a window, ends in the idle state;
// a read adds the histogram read state. A window close runs divide, k set-up,
// 16 radix select passes over the window ring port, binning and the update.
// A four-beat command queue lets requests land while the back end is busy.
// Reset is synchronous; the histogram clears through per-bin valid bits.
`default_nettype none
module sliding_window_quantile_histogram (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_error_value,
   input  wire logic [7:0]  req_bin_index,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_kind,
   output logic [7:0]       rsp_bin,
   output logic [19:0]      rsp_bin_count,
   output logic [19:0]      rsp_windows_done,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);

   swqh_pkg::cfg_type cfg_ff, cfg_in;
   swqh_pkg::cmd_type cmd;
   swqh_pkg::rsp_type rsp_in_data, rsp_out_data;
   logic cmd_valid, cmd_pop, rsp_full, rsp_push;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            swqh_pkg::CSR_WIDTH:   cfg_in.window_width   = csr_wdata[10:0];
            swqh_pkg::CSR_STEP:    cfg_in.window_step    = csr_wdata[15:0];
            swqh_pkg::CSR_PERCENT: cfg_in.percent_cutoff = csr_wdata[6:0];
            swqh_pkg::CSR_MAXWIN:  cfg_in.max_windows    = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_width   <= 11'd500;
         cfg_ff.window_step    <= 16'd100;
         cfg_ff.percent_cutoff <= 7'd80;
         cfg_ff.max_windows    <= 20'd100000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swqh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_error_value (req_error_value),
      .req_bin_index   (req_bin_index),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   swqh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data)
   );

   swqh_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_data)
   );

   assign rsp_kind         = rsp_out_data.kind;
   assign rsp_bin          = rsp_out_data.bin;
   assign rsp_bin_count    = rsp_out_data.bin_count;
   assign rsp_windows_done = rsp_out_data.windows_done;

   // the back end never writes into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result written into full queue");

   // a command is only taken with room for its result
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && !rsp_full))
      else $error("command taken without result room");

   // out-of-range reads answer zero
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == swqh_pkg::KIND_READ &&
       rsp_bin >= 8'(swqh_pkg::NUM_BINS)) |-> (rsp_bin_count == '0))
      else $error("out-of-range read returned a count");

   // a window result names a real bin that has been counted
   a_window_bin: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == swqh_pkg::KIND_WINDOW) |->
      (rsp_bin < 8'(swqh_pkg::NUM_BINS) && rsp_bin_count != '0))
      else $error("bad window result");

endmodule
`default_nettype wire

/* sim/tb_sliding_window_quantile_histogram.sv */
// Self-checking bench for the sliding window quantile histogram.
// Depends on swqh_pkg and the RTL top; a built-in predictor tracks window,
// histogram and registers and every response beat is checked against it.
`timescale 1ns / 1ps
module tb_sliding_window_quantile_histogram;

   localparam logic [1:0] OP_IDLE_CODE = 2'd3;  // unused op, no response
   localparam int SETTLE_CYCLES = 100;
   localparam int PEND_DEPTH = 64;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_op;
   logic [15:0] req_error_value;
   logic [7:0]  req_bin_index;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_kind;
   logic [7:0]  rsp_bin;
   logic [19:0] rsp_bin_count;
   logic [19:0] rsp_windows_done;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   sliding_window_quantile_histogram uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_op(req_op),
      .req_error_value(req_error_value), .req_bin_index(req_bin_index),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_kind(rsp_kind),
      .rsp_bin(rsp_bin), .rsp_bin_count(rsp_bin_count),
      .rsp_windows_done(rsp_windows_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [10:0]        cfg_width;
   logic [15:0]        cfg_step;
   logic [6:0]         cfg_pct;
   logic [19:0]        cfg_maxwin;
   logic [15:0]        ring_mem [swqh_pkg::WINDOW_MAX];
   int unsigned        ring_fill;
   int unsigned        ring_head;
   int unsigned        slides;
   logic [19:0]        total_windows;
   logic [19:0]        hist_mem [swqh_pkg::NUM_BINS];

   // expected responses, oldest at pend_rd
   swqh_pkg::rsp_type  pending_mem [PEND_DEPTH];
   int unsigned        pend_wr = 0;
   int unsigned        pend_rd = 0;
   int                 fail_count = 0;
   int                 items_sent = 0;
   int                 burst_left = 0;

   always #1 clock = ~clock;

   // k-th smallest of the n entries held, oldest first
   function automatic logic [15:0] kth_smallest(int unsigned n, int unsigned k);
      int unsigned below, upto;
      logic [15:0] v;
      logic [15:0] w;
      for (int unsigned i = 0; i < n; i++) begin
         v = ring_mem[(ring_head + i) % swqh_pkg::WINDOW_MAX];
         below = 0;
         upto = 0;
         for (int unsigned j = 0; j < n; j++) begin
            w = ring_mem[(ring_head + j) % swqh_pkg::WINDOW_MAX];
            if (w < v) below++;
            if (w <= v) upto++;
         end
         if (below <= k && k < upto) return v;
      end
      return '0;
   endfunction

   // update the predicted state for one accepted beat; 1 if it yields a response
   function automatic bit predict_window(input logic [1:0] op, input logic [15:0] value,
                                         input logic [7:0] bidx,
                                         output swqh_pkg::rsp_type r);
      int unsigned wid, stp, n, k, q, b;
      r = '0;
      if (op == swqh_pkg::OP_BREAK) begin
         ring_fill = 0;
         ring_head = 0;
         slides = 0;
         return 0;
      end
      if (op == swqh_pkg::OP_READ) begin
         r.kind = swqh_pkg::KIND_READ;
         r.bin = bidx;
         r.bin_count = (bidx < swqh_pkg::NUM_BINS) ? hist_mem[bidx] : '0;
         r.windows_done = total_windows;
         return 1;
      end
      if (op != swqh_pkg::OP_SAMPLE) return 0;
      if (total_windows >= cfg_maxwin) return 0;
      wid = (cfg_width == 0) ? 1 :
            ((cfg_width > swqh_pkg::WINDOW_MAX) ? swqh_pkg::WINDOW_MAX : 32'(cfg_width));
      stp = (cfg_step == 0) ? 1 : 32'(cfg_step);
      if (ring_fill < wid) begin
         ring_mem[(ring_head + ring_fill) % swqh_pkg::WINDOW_MAX] = value;
         ring_fill++;
         return 0;
      end
      ring_mem[ring_head] = value;
      ring_head = (ring_head + 1) % swqh_pkg::WINDOW_MAX;
      if (slides < 16'hFFFF) slides++;
      if (slides < stp) return 0;
      n = ring_fill;
      k = (n * 32'(cfg_pct)) / 100;
      if (k > n - 1) k = n - 1;
      q = 32'(kth_smallest(n, k));
      if (q > swqh_pkg::CUTOFF_Q88) q = 32'(swqh_pkg::CUTOFF_Q88);
      b = (q * 32'(swqh_pkg::BIN_RES)) >> 8;
      if (b > swqh_pkg::NUM_BINS - 1) b = swqh_pkg::NUM_BINS - 1;
      if (hist_mem[b] != swqh_pkg::COUNT_MAX) hist_mem[b]++;
      total_windows++;
      slides = 0;
      r.kind = swqh_pkg::KIND_WINDOW;
      r.bin = 8'(b);
      r.bin_count = hist_mem[b];
      r.windows_done = total_windows;
      return 1;
   endfunction

   // send one request beat; the sender runs in bursts with random gaps
   task automatic send_item(input logic [1:0] op, input logic [15:0] value,
                            input logic [7:0] bidx);
      bit taken;
      swqh_pkg::rsp_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_op <= op;
      req_error_value <= value;
      req_bin_index <= bidx;
      do begin
         @(negedge clock);
         taken = !req_full;
         @(posedge clock);
      end while (!taken);
      if (predict_window(op, value, bidx, r)) begin
         pending_mem[pend_wr % PEND_DEPTH] = r;
         pend_wr++;
      end
      items_sent++;
   endtask

   // let the block go idle: all responses in, then a settling pause
   task automatic wait_idle();
      req_push <= 1'b0;
      burst_left = 0;
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write; the enable is then dropped again before the next write
   task automatic csr_write(input logic [1:0] idx, input logic [19:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         swqh_pkg::CSR_WIDTH:   cfg_width = data[10:0];
         swqh_pkg::CSR_STEP:    cfg_step = data[15:0];
         swqh_pkg::CSR_PERCENT: cfg_pct = data[6:0];
         default:               cfg_maxwin = data;
      endcase
   endtask

   task automatic set_config(input logic [19:0] wid, input logic [19:0] stp,
                             input logic [19:0] pct);
      csr_write(swqh_pkg::CSR_WIDTH, wid);
      csr_write(swqh_pkg::CSR_STEP, stp);
      csr_write(swqh_pkg::CSR_PERCENT, pct);
   endtask

   function automatic logic [15:0] rand_sample();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 1400));
   endfunction

   // directed: edges of every field, every op, width 1 / step 1 windows
   task automatic test_directed();
      send_item(swqh_pkg::OP_READ, 16'h0000, 8'd0);
      send_item(swqh_pkg::OP_READ, 16'hFFFF, 8'd250);
      send_item(swqh_pkg::OP_READ, 16'h0000, 8'd251);
      send_item(swqh_pkg::OP_READ, 16'h0000, 8'd255);
      send_item(OP_IDLE_CODE, 16'hFFFF, 8'hFF);
      wait_idle();
      set_config(20'd1, 20'd1, 20'd100);
      send_item(swqh_pkg::OP_SAMPLE, 16'd0, 8'd0);       // fills
      send_item(swqh_pkg::OP_SAMPLE, 16'hFFFF, 8'hFF);   // clamps to top bin
      send_item(swqh_pkg::OP_SAMPLE, 16'd1280, 8'd0);
      send_item(swqh_pkg::OP_SAMPLE, 16'd1279, 8'd0);
      send_item(swqh_pkg::OP_SAMPLE, 16'd6, 8'd0);
      send_item(swqh_pkg::OP_BREAK, 16'hFFFF, 8'd0);
      send_item(swqh_pkg::OP_SAMPLE, 16'd512, 8'd0);
      send_item(swqh_pkg::OP_SAMPLE, 16'd513, 8'd0);
      send_item(swqh_pkg::OP_READ, 16'd0, 8'd250);
      send_item(swqh_pkg::OP_READ, 16'd0, 8'd0);
      wait_idle();
      // percent 0, above 100, width and step of zero
      set_config(20'd4, 20'd0, 20'd0);
      for (int i = 0; i < 6; i++) send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      wait_idle();
      csr_write(swqh_pkg::CSR_PERCENT, 20'h7F);
      csr_write(swqh_pkg::CSR_WIDTH, 20'd0);   // narrower than the fill: keeps sliding
      for (int i = 0; i < 4; i++) send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      send_item(swqh_pkg::OP_BREAK, 16'd0, 8'd0);
      for (int i = 0; i < 3; i++) send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      wait_idle();
   endtask

   // widest window, then an over-range width that acts as the widest
   task automatic test_wide_window();
      send_item(swqh_pkg::OP_BREAK, 16'd0, 8'd0);
      wait_idle();
      set_config(20'd1024, 20'd2, 20'd50);
      for (int i = 0; i < swqh_pkg::WINDOW_MAX + 2; i++) begin
         send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      end
      wait_idle();
      csr_write(swqh_pkg::CSR_WIDTH, 20'h7FF);
      for (int i = 0; i < 4; i++) send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      wait_idle();
      send_item(swqh_pkg::OP_BREAK, 16'd0, 8'd0);
      wait_idle();
   endtask

   // window limit: samples ignored, breaks and reads still served
   task automatic test_window_limit();
      set_config(20'd2, 20'd1, 20'd80);
      csr_write(swqh_pkg::CSR_MAXWIN, total_windows + 20'd3);
      for (int i = 0; i < 10; i++) send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      send_item(swqh_pkg::OP_BREAK, 16'd0, 8'd0);
      send_item(swqh_pkg::OP_SAMPLE, 16'd100, 8'd0);
      send_item(swqh_pkg::OP_READ, 16'd0, 8'($urandom_range(0, 250)));
      wait_idle();
      csr_write(swqh_pkg::CSR_MAXWIN, 20'hFFFFF);
      csr_write(swqh_pkg::CSR_STEP, 20'hFFFF);
      for (int i = 0; i < 4; i++) send_item(swqh_pkg::OP_SAMPLE, rand_sample(), 8'd0);
      wait_idle();
   endtask

   // random phases: mostly samples on small windows, some reads, breaks, noise
   task automatic test_random();
      int sel, len;
      int start_count;
      int unsigned wid_sel, pct_sel;
      start_count = items_sent;
      while (items_sent - start_count < 650) begin
         wid_sel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                               : $urandom_range(1, 12);
         pct_sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                               : 100 * $urandom_range(0, 1);
         set_config(20'(wid_sel), 20'($urandom_range(0, 5)), 20'(pct_sel));
         len = $urandom_range(80, 200);
         for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) send_item(swqh_pkg::OP_SAMPLE, rand_sample(),
                                    8'($urandom_range(0, 255)));
            else if (sel < 90) send_item(swqh_pkg::OP_READ, 16'($urandom_range(0, 65535)),
                                         8'($urandom_range(0, 255)));
            else if (sel < 96) send_item(swqh_pkg::OP_BREAK, 16'($urandom_range(0, 65535)),
                                         8'($urandom_range(0, 255)));
            else send_item(OP_IDLE_CODE, 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)));
         end
         wait_idle();
      end
   endtask

   // response side: pop on a stall pattern of its own, check each beat
   initial begin
      int unsigned cyc;
      int stall_len;
      bit taken;
      swqh_pkg::rsp_type got;
      swqh_pkg::rsp_type want;
      cyc = 0;
      stall_len = 0;
      forever begin
         @(negedge clock);
         taken = rsp_pop && !rsp_empty && !reset;
         got = {rsp_kind, rsp_bin, rsp_bin_count, rsp_windows_done};
         @(posedge clock);
         if (taken) begin
            if (pend_wr == pend_rd) begin
               $error("unexpected response beat kind=%0d bin=%0d", got.kind, got.bin);
               fail_count++;
            end else begin
               want = pending_mem[pend_rd % PEND_DEPTH];
               pend_rd++;
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  fail_count++;
               end
               if (got.bin !== want.bin) begin
                  $error("bin: expected %0d, got %0d", want.bin, got.bin);
                  fail_count++;
               end
               if (got.bin_count !== want.bin_count) begin
                  $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
                  fail_count++;
               end
               if (got.windows_done !== want.windows_done) begin
                  $error("windows_done: expected %0d, got %0d",
                         want.windows_done, got.windows_done);
                  fail_count++;
               end
            end
         end
         cyc++;
         if (cyc % 64 == 0) stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         rsp_pop <= ((cyc % 8) >= stall_len);
      end
   end

   // main sequence
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_op = swqh_pkg::OP_SAMPLE;
      req_error_value = '0;
      req_bin_index = '0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_index = swqh_pkg::CSR_WIDTH;
      csr_wdata = '0;
      cfg_width = 11'd500;
      cfg_step = 16'd100;
      cfg_pct = 7'd80;
      cfg_maxwin = 20'd100000;
      ring_fill = 0;
      ring_head = 0;
      slides = 0;
      total_windows = '0;
      for (int i = 0; i < swqh_pkg::WINDOW_MAX; i++) ring_mem[i] = '0;
      for (int i = 0; i < swqh_pkg::NUM_BINS; i++) hist_mem[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_wide_window();
      test_window_limit();
      test_random();
      wait_idle();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #40000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sliding_window_quantile_histogram.f */
hdl/swqh_pkg.sv
hdl/swqh_front.sv
hdl/swqh_rsp_fifo.sv
hdl/swqh_back.sv
hdl/sliding_window_quantile_histogram.sv
sim/tb_sliding_window_quantile_histogram.sv
